// File: rtl/dhtswr_pkg.sv
// Package for the single-wire humidity sensor reader.
// Holds the phase and status codes, register indexes, reset values and the result word type.
// No dependencies.
`default_nettype none

package dhtswr_pkg;

  localparam int FRAME_BITS = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0]  PULSE_LIMIT        = 8'hFF;
  localparam logic [15:0] START_LOW_RESET    = 16'd18000;
  localparam logic [7:0]  RELEASE_HIGH_RESET = 8'd30;
  localparam logic [7:0]  BIT_THRESH_RESET   = 8'd48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_LOW    = 2'd0,
    CFG_RELEASE_HIGH = 2'd1,
    CFG_BIT_THRESH   = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_START_LOW  = 3'd1,
    PH_START_HIGH = 3'd2,
    PH_RESP_LOW   = 3'd3,
    PH_RESP_HIGH  = 3'd4,
    PH_BIT_LOW    = 3'd5,
    PH_BIT_HIGH   = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TIMEOUT  = 2'd1,
    ST_CHECKSUM = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] start_low_ticks;
    logic [7:0]  release_high_ticks;
    logic [7:0]  bit_threshold;
  } cfg_t;

  typedef struct packed {
    logic        drive_enable;
    logic        drive_level;
    logic        busy;
    logic        done;
    status_t     status;
    logic        changed;
    logic [31:0] reading;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/dht11_single_wire_reader.sv
// Single-wire humidity sensor reader, top level: configuration registers, read
// sequencer and output buffer. Depends on dhtswr_pkg and the dhtswr_* modules.
//
// Each input word is either a start command or one microsecond tick with the sampled
// data-line level, and each word yields exactly one result word showing the drive
// controls, busy, done with status, the change flag and the stored reading. The block
// takes one word per clock cycle while in_stall is low; each result is registered in the
// output register, or in the skid stage while the output register is held. The phase
// machine, pulse timer and checksum are combinational between the state registers, so
// the only limit on rate is the output side: a skid stage holds one extra result, and
// in_stall rises only while both the output register and the skid stage are full.
`default_nettype none

module dht11_single_wire_reader
  import dhtswr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write_enable,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  func,
  input  wire logic                  line_level,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       drive_enable,
  output logic                       drive_level,
  output logic                       busy_res,
  output logic                       done_res,
  output logic [1:0]                 status,
  output logic                       changed,
  output logic [31:0]                reading
);

  cfg_t    cfg;
  result_t core_result;
  result_t out_data;
  logic    accept;

  assign accept = in_valid && !in_stall;

  dhtswr_cfg_regs u_cfg_regs (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cfg              (cfg)
  );

  dhtswr_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .func       (func),
    .line_level (line_level),
    .result     (core_result)
  );

  dhtswr_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (core_result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .full      (in_stall)
  );

  assign drive_enable = out_data.drive_enable;
  assign drive_level  = out_data.drive_level;
  assign busy_res     = out_data.busy;
  assign done_res     = out_data.done;
  assign status       = out_data.status;
  assign changed      = out_data.changed;
  assign reading      = out_data.reading;

  // The input side only stalls when a result is already waiting.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result held");

  // The word that ends a reading leaves the block idle.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> (!busy_res && !drive_enable))
    else $error("done result shows a busy reader");

  // A change is reported only on a good reading.
  a_changed_is_good: assert property (@(posedge clk) disable iff (rst)
    (out_valid && changed) |-> (done_res && status == ST_OK))
    else $error("change flag outside a good reading");

  // Status is non-zero only with done.
  a_status_with_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !done_res) |-> (status == ST_OK))
    else $error("status set without done");

endmodule

`default_nettype wire

// File: rtl/dhtswr_cfg_regs.sv
// Configuration registers of the sensor reader: start timing and bit threshold.
// Depends on dhtswr_pkg.
`default_nettype none

module dhtswr_cfg_regs
  import dhtswr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write_enable,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_low_ticks    <= START_LOW_RESET;
      cfg.release_high_ticks <= RELEASE_HIGH_RESET;
      cfg.bit_threshold      <= BIT_THRESH_RESET;
    end else if (cfg_write_enable) begin
      // An index past the register list is ignored.
      unique case (cfg_index)
        CFG_START_LOW:    cfg.start_low_ticks    <= cfg_data;
        CFG_RELEASE_HIGH: cfg.release_high_ticks <= cfg_data[7:0];
        CFG_BIT_THRESH:   cfg.bit_threshold      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/dhtswr_core.sv
// Read sequencer: phase machine, pulse timer, bit shifter, checksum and stored reading.
// Produces one result word per accepted word. Depends on dhtswr_pkg.
`default_nettype none

module dhtswr_core
  import dhtswr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic accept,
  input  wire logic func,
  input  wire logic line_level,
  output result_t   result
);

  phase_t                phase, phase_next;
  logic [15:0]           tick_count, tick_count_next;
  logic [5:0]            bit_index, bit_index_next;
  logic [FRAME_BITS-1:0] received_bytes, received_bytes_next;
  logic [31:0]           stored_reading, stored_reading_next;

  logic        done, changed;
  status_t     status;
  logic [15:0] tick_inc;
  logic [5:0]  bit_inc;
  logic        pulse_limit_hit;
  logic [FRAME_BITS-1:0] shifted;
  logic [7:0]  sum;
  logic [31:0] new_reading;

  assign tick_inc        = tick_count + 16'd1;
  assign bit_inc         = bit_index + 6'd1;
  assign pulse_limit_hit = (tick_inc >= {8'd0, PULSE_LIMIT});
  assign shifted = {received_bytes[FRAME_BITS-2:0], (tick_count > {8'd0, cfg.bit_threshold})};
  assign sum = shifted[39:32] + shifted[31:24] + shifted[23:16] + shifted[15:8];
  // Byte 0 is the first byte on the wire and lands in the low bits of the reading.
  assign new_reading = {shifted[15:8], shifted[23:16], shifted[31:24], shifted[39:32]};

  always_comb begin
    phase_next          = phase;
    tick_count_next     = tick_count;
    bit_index_next      = bit_index;
    received_bytes_next = received_bytes;
    stored_reading_next = stored_reading;
    done                = 1'b0;
    status              = ST_OK;
    changed             = 1'b0;
    if (func) begin
      phase_next          = PH_START_LOW;
      tick_count_next     = '0;
      bit_index_next      = '0;
      received_bytes_next = '0;
    end else begin
      unique case (phase)
        PH_IDLE: ;
        PH_START_LOW: begin
          tick_count_next = tick_inc;
          if (tick_inc >= cfg.start_low_ticks) begin
            phase_next      = PH_START_HIGH;
            tick_count_next = '0;
          end
        end
        PH_START_HIGH: begin
          tick_count_next = tick_inc;
          if (tick_inc >= {8'd0, cfg.release_high_ticks}) begin
            phase_next      = PH_RESP_LOW;
            tick_count_next = '0;
          end
        end
        PH_RESP_LOW, PH_RESP_HIGH: begin
          // A response pulse that runs long is not an error; data timing starts over.
          if (line_level == (phase == PH_RESP_HIGH)) begin
            tick_count_next = tick_inc;
            if (pulse_limit_hit) begin
              phase_next      = PH_BIT_LOW;
              tick_count_next = '0;
            end
          end else begin
            phase_next      = (phase == PH_RESP_LOW) ? PH_RESP_HIGH : PH_BIT_LOW;
            tick_count_next = 16'd1;
          end
        end
        PH_BIT_LOW: begin
          if (!line_level) begin
            tick_count_next = tick_inc;
            if (pulse_limit_hit) begin
              done       = 1'b1;
              status     = ST_TIMEOUT;
              phase_next = PH_IDLE;
            end
          end else begin
            phase_next      = PH_BIT_HIGH;
            tick_count_next = 16'd1;
          end
        end
        PH_BIT_HIGH: begin
          if (line_level) begin
            tick_count_next = tick_inc;
            if (pulse_limit_hit) begin
              done       = 1'b1;
              status     = ST_TIMEOUT;
              phase_next = PH_IDLE;
            end
          end else begin
            received_bytes_next = shifted;
            bit_index_next      = bit_inc;
            if (bit_inc >= 6'(FRAME_BITS)) begin
              done       = 1'b1;
              phase_next = PH_IDLE;
              if (shifted[7:0] != sum) begin
                status = ST_CHECKSUM;
              end else if (new_reading != stored_reading) begin
                changed             = 1'b1;
                stored_reading_next = new_reading;
              end
            end else begin
              phase_next      = PH_BIT_LOW;
              tick_count_next = 16'd1;
            end
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  // The result shows the state after the word has been applied.
  always_comb begin
    result.drive_enable = (phase_next == PH_START_LOW) || (phase_next == PH_START_HIGH);
    result.drive_level  = (phase_next == PH_START_HIGH);
    result.busy         = (phase_next != PH_IDLE);
    result.done         = done;
    result.status       = status;
    result.changed      = changed;
    result.reading      = stored_reading_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      tick_count     <= '0;
      bit_index      <= '0;
      received_bytes <= '0;
      stored_reading <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      tick_count     <= tick_count_next;
      bit_index      <= bit_index_next;
      received_bytes <= received_bytes_next;
      stored_reading <= stored_reading_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/dhtswr_out_buf.sv
// Output register with a one-word skid stage for the sensor reader results.
// The stall toward the input side comes from a register. Depends on dhtswr_pkg.
`default_nettype none

module dhtswr_out_buf
  import dhtswr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  input  wire logic    out_stall,
  output logic         out_valid,
  output result_t      out_data,
  output logic         full
);

  logic    skid_valid;
  result_t skid_data;
  logic    take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  // A push never meets a full skid stage, since the input is stalled then.
  always_ff @(posedge clk) begin
    if (take) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule

`default_nettype wire
